// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the tilt filter RTL.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define TCF_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition is followed by another in the next cycle.
`define TCF_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/tcf_pkg.sv -----
// Package for the tilt complementary filter: widths, register codes, sequencer states
// and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tcf_pkg;

	localparam int CAL_SAMPLES  = 200;
	localparam int CORDIC_ITERS = 16;
	localparam int ATAN_LEN     = 24;
	localparam int N_ITERS      = (CORDIC_ITERS < ATAN_LEN) ? CORDIC_ITERS : ATAN_LEN;
	localparam int IT_W         = $clog2(ATAN_LEN + 1);

	localparam int SMP_W   = 16;
	localparam int ACC_W   = 24;
	localparam int CAL_W   = 8;
	localparam int SQ_W    = 32;
	localparam int RAD_W   = 48;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int ROOT_IT = RAD_W / 2;
	localparam int RIT_W   = $clog2(ROOT_IT + 1);
	localparam int CX_W    = 28;
	localparam int CZ_W    = 25;
	localparam int TAB_W   = 23;
	localparam int DIV_W   = $clog2(CAL_SAMPLES + 1) + 1;
	localparam int DIV_IT  = ACC_W;
	localparam int DIT_W   = $clog2(DIV_IT + 1);

	localparam int MA_W   = 28;
	localparam int MB_W   = 25;
	localparam int PROD_W = MA_W + MB_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int STEP_W = 27;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;
	localparam int GW_W      = 16;
	localparam int GAIN_W    = 24;

	localparam logic [GW_W-1:0]   GYRO_WEIGHT_RST  = 16'd31457;
	localparam logic [GW_W-1:0]   ACCEL_WEIGHT_RST = 16'd655;
	localparam logic [GAIN_W-1:0] STEP_GAIN_RST    = 24'd10230;
	localparam logic [SMP_W-1:0]  SERVO_CENTER_RST = 16'd1500;
	localparam logic [SMP_W-1:0]  SERVO_GAIN_RST   = 16'd1920;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GYRO_WEIGHT    = 3'd0,
		REG_ACCEL_WEIGHT   = 3'd1,
		REG_GYRO_STEP_GAIN = 3'd2,
		REG_SERVO_CENTER   = 3'd3,
		REG_SERVO_GAIN     = 3'd4
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CAL, ST_DIVS, ST_DIV,
		ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_ROOT, ST_ANG,
		ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_F7, ST_OUT
	} state_t;

	// atan(2^-i) in degrees, Q16.
	function automatic logic [TAB_W-1:0] atan_tab(input logic [IT_W-1:0] idx);
		case (idx)
			0:  atan_tab = TAB_W'(2949120);
			1:  atan_tab = TAB_W'(1740967);
			2:  atan_tab = TAB_W'(919879);
			3:  atan_tab = TAB_W'(466945);
			4:  atan_tab = TAB_W'(234379);
			5:  atan_tab = TAB_W'(117304);
			6:  atan_tab = TAB_W'(58666);
			7:  atan_tab = TAB_W'(29335);
			8:  atan_tab = TAB_W'(14668);
			9:  atan_tab = TAB_W'(7334);
			10: atan_tab = TAB_W'(3667);
			11: atan_tab = TAB_W'(1833);
			12: atan_tab = TAB_W'(917);
			13: atan_tab = TAB_W'(458);
			14: atan_tab = TAB_W'(229);
			15: atan_tab = TAB_W'(115);
			16: atan_tab = TAB_W'(57);
			17: atan_tab = TAB_W'(29);
			18: atan_tab = TAB_W'(14);
			19: atan_tab = TAB_W'(7);
			20: atan_tab = TAB_W'(4);
			21: atan_tab = TAB_W'(2);
			22: atan_tab = TAB_W'(1);
			default: atan_tab = '0;
		endcase
	endfunction

endpackage
`default_nettype wire

// ----- rtl/tcf_div.sv -----
// Bit-serial divider that averages a calibration sum into a gyro bias.
// Depends on tcf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcf_div import tcf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] sum,
	output logic                    done,
	output logic signed [ACC_W-1:0] bias
);

	logic             busy_q, done_q, neg_q;
	logic [DIT_W-1:0] cnt_q;
	logic [ACC_W-1:0] dvd_q, mag;
	logic [DIV_W-2:0] rem_q;
	logic [DIV_W-1:0] trial;
	logic             ge;

	assign mag   = (sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum)) + ACC_W'(CAL_SAMPLES / 2);
	assign trial = {rem_q, dvd_q[ACC_W-1]};
	assign ge    = trial >= DIV_W'(CAL_SAMPLES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIT_W'(DIV_IT - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= mag;
			rem_q <= '0;
			neg_q <= sum[ACC_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? (DIV_W-1)'(trial - DIV_W'(CAL_SAMPLES)) : trial[DIV_W-2:0];
			dvd_q <= {dvd_q[ACC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign bias = neg_q ? -$signed(dvd_q) : $signed(dvd_q);

endmodule
`default_nettype wire

// ----- rtl/tcf_sqrt.sv -----
// Digit-serial integer square root, two radicand bits per cycle.
// Depends on tcf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcf_sqrt import tcf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   sq,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic              busy_q, done_q;
	logic [RIT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+3:0] cur, trial;
	logic              ge;

	assign cur   = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == RIT_W'(ROOT_IT - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= {sq, (RAD_W - SQ_W)'(0)};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? (ROOT_W+2)'(cur - trial) : (ROOT_W+2)'(cur);
			root_q <= {root_q[ROOT_W-2:0], ge};
			rad_q  <= rad_q << 2;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// ----- rtl/tcf_cordic.sv -----
// Iterative vectoring CORDIC that turns a root and a numerator into an angle in
// degrees Q8.8. Depends on tcf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcf_cordic import tcf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [ROOT_W-1:0]       x0,
	input  logic signed [SMP_W-1:0] num,
	output logic                    done,
	output logic signed [SMP_W-1:0] ang
);

	logic                   busy_q, done_q, zero_q;
	logic [IT_W-1:0]        i_q;
	logic signed [CX_W-1:0] x_q, y_q, dx, dy;
	logic signed [CZ_W-1:0] z_q, tab_s, z_half, zr;

	assign dx     = y_q >>> i_q;
	assign dy     = x_q >>> i_q;
	assign tab_s  = signed'(CZ_W'(atan_tab(i_q)));
	assign z_half = CZ_W'(128);
	assign zr     = (z_q + z_half) >>> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == IT_W'(N_ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= signed'(CX_W'(x0));
			y_q    <= {{(CX_W - SMP_W - 8){num[SMP_W-1]}}, num, 8'd0};
			z_q    <= '0;
			zero_q <= (x0 == '0) && (num == '0);
		end else if (busy_q) begin
			if (!y_q[CX_W-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + tab_s;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - tab_s;
			end
		end
	end

	assign done = done_q;
	assign ang  = zero_q ? '0 : zr[SMP_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/tilt_complementary_filter.sv -----
// Tilt estimator. The first 200 sample sets after reset only calibrate the gyro bias and give
// no result; the last of them also runs the bias divider. Every later set gives pitch, roll
// and a servo compare value, worked out by the 24-step square root and the 16-step CORDIC,
// which run for pitch and roll side by side, followed by eight steps of one shared
// multiplier. One set is worked on at a time; a finished result waits in the output register
// while the next set is taken. Depends on tcf_pkg and the tcf units.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tilt_complementary_filter import tcf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y from bit 0 up
	input  logic [5*SMP_W-1:0]   s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// pitch_deg, roll_deg, servo_compare from bit 0 up
	output logic [3*SMP_W-1:0]   m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [GW_W-1:0]   gyro_weight_q, accel_weight_q;
	logic [GAIN_W-1:0] step_gain_q;
	logic [SMP_W-1:0]  servo_center_q, servo_gain_q;

	logic [CAL_W-1:0]        cal_count_q;
	logic signed [ACC_W-1:0] sum_gx_q, sum_gy_q, bias_gx_q, bias_gy_q;
	logic signed [SMP_W-1:0] pitch_prev_q, roll_prev_q;
	logic                    out_valid_q;

	logic signed [SMP_W-1:0]  ax_q, ay_q, az_q, gx_q, gy_q;
	logic [SQ_W-1:0]          sax_q, saz_q, sq_p, sq_r;
	logic signed [STEP_W-1:0] step_p_q, step_r_q;
	logic signed [PROD_W-1:0] prod_q, t_q, half16, step_full;
	logic [SMP_W-1:0]         servo_q;
	logic [3*SMP_W-1:0]       out_q;

	logic signed [MA_W-1:0]  mul_a;
	logic signed [MB_W-1:0]  mul_b;
	logic signed [ACC_W:0]   rate_x, rate_y;
	logic signed [SUM_W-1:0] filt_sum, half14, srv_sum, srv_sh, srv_hi;
	logic signed [SMP_W-1:0] filt_res;
	logic [SMP_W-1:0]        srv_clamp;

	logic div_start, div_done_x, div_done_y, sqrt_start, sqrt_done_p, sqrt_done_r;
	logic cor_start, cor_done_p, cor_done_r, load;
	logic signed [ACC_W-1:0] bias_x, bias_y;
	logic [ROOT_W-1:0]       root_p, root_r;
	logic signed [SMP_W-1:0] ang_p, ang_r;
	logic                    units_in_step, cal_quiet;

	function automatic logic signed [SMP_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi, lo;
		hi = SUM_W'(32767);
		lo = -hi - SUM_W'(1);
		if (v > hi) sat16 = 16'sh7fff;
		else if (v < lo) sat16 = 16'sh8000;
		else sat16 = v[SMP_W-1:0];
	endfunction

	tcf_div u_div_x (.clk, .arst_n, .start(div_start), .sum(sum_gx_q), .done(div_done_x),
		.bias(bias_x));
	tcf_div u_div_y (.clk, .arst_n, .start(div_start), .sum(sum_gy_q), .done(div_done_y),
		.bias(bias_y));

	assign sq_p = sax_q + saz_q;
	assign sq_r = SQ_W'(prod_q) + saz_q;

	tcf_sqrt u_sqrt_p (.clk, .arst_n, .start(sqrt_start), .sq(sq_p), .done(sqrt_done_p),
		.root(root_p));
	tcf_sqrt u_sqrt_r (.clk, .arst_n, .start(sqrt_start), .sq(sq_r), .done(sqrt_done_r),
		.root(root_r));

	tcf_cordic u_cor_p (.clk, .arst_n, .start(cor_start), .x0(root_p), .num(ay_q),
		.done(cor_done_p), .ang(ang_p));
	tcf_cordic u_cor_r (.clk, .arst_n, .start(cor_start), .x0(root_r), .num(ax_q),
		.done(cor_done_r), .ang(ang_r));

	assign rate_x = (ACC_W+1)'(gx_q) - (ACC_W+1)'(bias_gx_q);
	assign rate_y = (ACC_W+1)'(gy_q) - (ACC_W+1)'(bias_gy_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ0: begin
				mul_a = MA_W'(ax_q);
				mul_b = MB_W'(ax_q);
			end
			ST_SQ1: begin
				mul_a = MA_W'(az_q);
				mul_b = MB_W'(az_q);
			end
			ST_SQ2: begin
				mul_a = MA_W'(ay_q);
				mul_b = MB_W'(ay_q);
			end
			ST_F0: begin
				mul_a = MA_W'(rate_x);
				mul_b = signed'(MB_W'(step_gain_q));
			end
			ST_F1: begin
				mul_a = MA_W'(rate_y);
				mul_b = signed'(MB_W'(step_gain_q));
			end
			ST_F2: begin
				mul_a = MA_W'(step_p_q) + MA_W'(pitch_prev_q);
				mul_b = signed'(MB_W'(gyro_weight_q));
			end
			ST_F3: begin
				mul_a = MA_W'(ang_p);
				mul_b = signed'(MB_W'(accel_weight_q));
			end
			ST_F4: begin
				mul_a = MA_W'(step_r_q) + MA_W'(roll_prev_q);
				mul_b = signed'(MB_W'(gyro_weight_q));
			end
			ST_F5: begin
				mul_a = MA_W'(ang_r);
				mul_b = signed'(MB_W'(accel_weight_q));
			end
			ST_F6: begin
				mul_a = MA_W'(pitch_prev_q);
				mul_b = signed'(MB_W'(servo_gain_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign half16    = PROD_W'(32768);
	assign step_full = (prod_q + half16) >>> 16;
	assign half14    = SUM_W'(16384);
	assign filt_sum  = SUM_W'(t_q) + SUM_W'(prod_q);
	assign filt_res  = sat16((filt_sum + half14) >>> 15);
	assign srv_sum   = (SUM_W'(signed'({1'b0, servo_center_q})) <<< 16) + SUM_W'(prod_q);
	assign srv_sh    = srv_sum >>> 16;
	assign srv_hi    = SUM_W'(65535);
	assign srv_clamp = srv_sh[SUM_W-1] ? '0 :
		(srv_sh > srv_hi) ? '1 : srv_sh[SMP_W-1:0];

	assign load = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		cor_start  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = (cal_count_q < CAL_W'(CAL_SAMPLES)) ? ST_CAL : ST_SQ0;
			end
			ST_CAL: begin
				state_d = (cal_count_q == CAL_W'(CAL_SAMPLES - 1)) ? ST_DIVS : ST_IDLE;
			end
			ST_DIVS: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done_x) state_d = ST_IDLE;
			end
			ST_SQ0: state_d = ST_SQ1;
			ST_SQ1: state_d = ST_SQ2;
			ST_SQ2: state_d = ST_SQ3;
			ST_SQ3: begin
				sqrt_start = 1'b1;
				state_d    = ST_ROOT;
			end
			ST_ROOT: begin
				if (sqrt_done_p) begin
					cor_start = 1'b1;
					state_d   = ST_ANG;
				end
			end
			ST_ANG: begin
				if (cor_done_p) state_d = ST_F0;
			end
			ST_F0: state_d = ST_F1;
			ST_F1: state_d = ST_F2;
			ST_F2: state_d = ST_F3;
			ST_F3: state_d = ST_F4;
			ST_F4: state_d = ST_F5;
			ST_F5: state_d = ST_F6;
			ST_F6: state_d = ST_F7;
			ST_F7: state_d = ST_OUT;
			ST_OUT: begin
				if (load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_weight_q  <= GYRO_WEIGHT_RST;
			accel_weight_q <= ACCEL_WEIGHT_RST;
			step_gain_q    <= STEP_GAIN_RST;
			servo_center_q <= SERVO_CENTER_RST;
			servo_gain_q   <= SERVO_GAIN_RST;
			cal_count_q    <= '0;
			sum_gx_q       <= '0;
			sum_gy_q       <= '0;
			bias_gx_q      <= '0;
			bias_gy_q      <= '0;
			pitch_prev_q   <= '0;
			roll_prev_q    <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					REG_GYRO_WEIGHT:    gyro_weight_q  <= cfg_data[GW_W-1:0];
					REG_ACCEL_WEIGHT:   accel_weight_q <= cfg_data[GW_W-1:0];
					REG_GYRO_STEP_GAIN: step_gain_q    <= cfg_data[GAIN_W-1:0];
					REG_SERVO_CENTER:   servo_center_q <= cfg_data[SMP_W-1:0];
					REG_SERVO_GAIN:     servo_gain_q   <= cfg_data[SMP_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_CAL) begin
				cal_count_q <= cal_count_q + 1'b1;
				sum_gx_q    <= sum_gx_q + ACC_W'(gx_q);
				sum_gy_q    <= sum_gy_q + ACC_W'(gy_q);
			end
			if (state_q == ST_DIV && div_done_x) begin
				bias_gx_q <= bias_x;
				bias_gy_q <= bias_y;
				sum_gx_q  <= '0;
				sum_gy_q  <= '0;
			end
			if (state_q == ST_F4) pitch_prev_q <= filt_res;
			if (state_q == ST_F6) roll_prev_q <= filt_res;
			if (load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == ST_IDLE && s_tvalid) begin
			ax_q <= s_tdata[SMP_W-1:0];
			ay_q <= s_tdata[2*SMP_W-1:SMP_W];
			az_q <= s_tdata[3*SMP_W-1:2*SMP_W];
			gx_q <= s_tdata[4*SMP_W-1:3*SMP_W];
			gy_q <= s_tdata[5*SMP_W-1:4*SMP_W];
		end
		if (state_q == ST_SQ1) sax_q <= SQ_W'(prod_q);
		if (state_q == ST_SQ2) saz_q <= SQ_W'(prod_q);
		if (state_q == ST_F1) step_p_q <= step_full[STEP_W-1:0];
		if (state_q == ST_F2) step_r_q <= step_full[STEP_W-1:0];
		if (state_q == ST_F3 || state_q == ST_F5) t_q <= prod_q;
		if (state_q == ST_F7) servo_q <= srv_clamp;
		if (load) out_q <= {servo_q, roll_prev_q, pitch_prev_q};
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	assign units_in_step = (sqrt_done_p == sqrt_done_r) && (cor_done_p == cor_done_r) &&
		(div_done_x == div_done_y);
	assign cal_quiet = (state_q == ST_CAL) && !out_valid_q;

	`TCF_ASSERT(a_units_in_step, units_in_step, "pitch and roll units out of step")
	`TCF_ASSERT(a_cal_bound, cal_count_q <= CAL_W'(CAL_SAMPLES), "calibration count overran")
	`TCF_ASSERT_NEXT(a_cal_silent, cal_quiet, !out_valid_q, "calibration set produced a result")

endmodule
`default_nettype wire
